// ----- rtl/stok_pkg.sv -----
// Package for the source tokenizer: token kinds, error codes, scan modes,
// table sizes and the delimiter / keyword lookup functions. No dependencies.
`default_nettype none
package stok_pkg;

  localparam int NAME_TABLE_SIZE = 128;
  localparam int NAME_CHARS      = 16;
  localparam int SLOT_W          = $clog2(NAME_TABLE_SIZE);
  localparam int CHAR_W          = $clog2(NAME_CHARS);
  localparam int LEN_W           = $clog2(NAME_CHARS + 1);
  localparam int STORE_DEPTH     = NAME_TABLE_SIZE * NAME_CHARS;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);

  localparam logic [30:0] NUM_MAX   = 31'h7FFF_FFFF;
  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    K_KEYWORD = 3'd0, K_DELIM = 3'd1, K_NUMBER = 3'd2, K_IDENT = 3'd3,
    K_STRING = 3'd4, K_END = 3'd5, K_ERROR = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    E_BRACKET = 3'd0, E_STRING = 3'd1, E_DELIM = 3'd2, E_LONG = 3'd3,
    E_FULL = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    M_START, M_SLASH, M_COMMENT, M_CSTAR, M_STRING, M_NUMBER, M_WORD,
    M_DELIM, M_HALT
  } mode_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SEARCH_RD, S_SEARCH_CMP, S_COPY, S_EMIT
  } seq_t;

  // Delimiter indexes that move the bracket depths.
  localparam logic [4:0] D_LPAREN = 5'd6;
  localparam logic [4:0] D_RPAREN = 5'd7;
  localparam logic [4:0] D_LBRACE = 5'd17;
  localparam logic [4:0] D_RBRACE = 5'd18;
  localparam logic [4:0] D_SLASH  = 5'd13;

  function automatic logic [4:0] single_delim(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h3B: r = 5'd1;
      8'h2C: r = 5'd3;
      8'h3A: r = 5'd4;
      8'h3D: r = 5'd5;
      8'h28: r = 5'd6;
      8'h29: r = 5'd7;
      8'h3C: r = 5'd8;
      8'h3E: r = 5'd9;
      8'h2B: r = 5'd10;
      8'h2D: r = 5'd11;
      8'h2A: r = 5'd12;
      8'h2F: r = 5'd13;
      8'h7B: r = 5'd17;
      8'h7D: r = 5'd18;
      8'h2E: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] pair_delim(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b == 8'h3D) begin
      case (a)
        8'h3D: r = 5'd2;
        8'h3C: r = 5'd14;
        8'h21: r = 5'd15;
        8'h3E: r = 5'd16;
        default: r = 5'd0;
      endcase
    end else if (a == 8'h2B && b == 8'h2B) begin
      r = 5'd19;
    end else if (a == 8'h2D && b == 8'h2D) begin
      r = 5'd20;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Keywords are at most eight characters; a word is packed low byte first.
  function automatic logic [4:0] keyword_index(input logic [63:0] w,
                                               input logic [LEN_W-1:0] len);
    logic [4:0] r;
    r = 5'd0;
    if (len <= LEN_W'(8)) begin
      case (w)
        64'h0000000000646E61: r = 5'd1;
        64'h000000006C6F6F62: r = 5'd2;
        64'h0000000000006F64: r = 5'd3;
        64'h0000000065736C65: r = 5'd4;
        64'h0000000000006669: r = 5'd5;
        64'h0000000000726F66: r = 5'd6;
        64'h00000065736C6166: r = 5'd7;
        64'h0000000000746E69: r = 5'd8;
        64'h0000000000746F6E: r = 5'd9;
        64'h000000000000726F: r = 5'd10;
        64'h006D6172676F7270: r = 5'd11;
        64'h0000000064616572: r = 5'd12;
        64'h0000006B61657262: r = 5'd13;
        64'h000000006F746F67: r = 5'd14;
        64'h0000000065757274: r = 5'd15;
        64'h0000676E69727473: r = 5'd16;
        64'h000000656C696877: r = 5'd17;
        64'h0000006574697277: r = 5'd18;
        default: r = 5'd0;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/source_tokenizer.sv -----
// Top level of the source tokenizer: scanner, name table search and output
// buffer. Depends on stok_pkg and stok_ram.
//
//   channel  direction  ports                                   beat
//   in       input      in_valid in_ready in_ch in_at_end        one character
//   out      output     out_valid out_ready out_kind out_value   one token
//                       out_error_code out_last
//
// An ordinary character is accepted in S_IDLE, scanned in S_SCAN and
// passes S_EMIT on its way back to S_IDLE, where queued tokens are offered.
// Ending an identifier walks the name table through one compare unit, a
// store read then a compare per character: a slot of another length is
// dropped at its first compare, and a new word is then copied into the
// store one character at a time. A multiply by ten for numbers is the other
// shared unit. Up to two tokens wait in a small output queue; the block
// takes no new beat until all queued tokens are delivered. Reset is
// synchronous and clears control state; the name store needs no clearing
// since only written slots are read.
`default_nettype none
module source_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_at_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [30:0]      out_value,
  output logic [2:0]       out_error_code,
  output logic             out_last
);

  localparam int SLOT_W = stok_pkg::SLOT_W;
  localparam int CHAR_W = stok_pkg::CHAR_W;
  localparam int LEN_W  = stok_pkg::LEN_W;
  localparam int AW     = stok_pkg::STORE_AW;

  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] value;
    logic [2:0]  err;
  } tok_t;

  // Architectural state.
  stok_pkg::seq_t  seq_r, seq_nxt;
  stok_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic        end_r, end_nxt;
  logic [7:0]  tok_r [stok_pkg::NAME_CHARS];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [30:0] num_r, num_nxt;
  logic [SLOT_W:0] next_slot_r, next_slot_nxt;
  logic [15:0] str_ord_r, str_ord_nxt;
  logic [15:0] paren_r, paren_nxt;
  logic [15:0] brace_r, brace_nxt;

  // Search / copy counters.
  logic [SLOT_W:0] slot_r, slot_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;

  // Output queue of up to two tokens.
  tok_t        q_r [2];
  tok_t        q_nxt [2];
  logic [1:0]  qn_r, qn_nxt;
  logic        qh_r, qh_nxt;
  logic [1:0]  qd_r, qd_nxt;

  logic        tok_we;
  logic [CHAR_W-1:0] tok_wa;
  logic [7:0]  tok_wd;

  // Name store and name lengths.
  logic          st_we;
  logic [AW-1:0] st_wa, st_ra;
  logic [7:0]    st_rd;
  logic          ln_we;
  logic [SLOT_W-1:0] ln_wa, ln_ra;
  logic [4:0]    ln_rd;

  stok_ram #(.WIDTH(8), .DEPTH(stok_pkg::STORE_DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(tok_r[pos_r[CHAR_W-1:0]]),
    .raddr(st_ra), .rdata(st_rd)
  );
  stok_ram #(.WIDTH(5), .DEPTH(stok_pkg::NAME_TABLE_SIZE)) u_lens (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(5'(len_r)),
    .raddr(ln_ra), .rdata(ln_rd)
  );

  // Packed first eight characters for the keyword lookup.
  logic [63:0] kw_word;
  logic [4:0]  kw_idx;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kw_word[i*8 +: 8] = (LEN_W'(i) < len_r && i < stok_pkg::NAME_CHARS) ?
                          tok_r[i % stok_pkg::NAME_CHARS] : 8'h00;
    end
    kw_idx = stok_pkg::keyword_index(kw_word, len_r);
  end

  // Shared multiply-by-ten unit for the number accumulator.
  logic [35:0] mul10;
  assign mul10 = {num_r, 3'b000} + {3'b000, num_r, 1'b0} + 36'(ch_r - 8'h30);

  assign in_ready  = (seq_r == stok_pkg::S_IDLE) && (qn_r == 2'd0);
  assign out_valid = (seq_r == stok_pkg::S_IDLE) && (qn_r != qd_r);
  assign out_kind       = q_r[qd_r[0]].kind;
  assign out_value      = q_r[qd_r[0]].value;
  assign out_error_code = q_r[qd_r[0]].err;
  assign out_last       = (qd_r + 2'd1) == qn_r;

  // Address generation for the store.
  always_comb begin
    st_ra = AW'(slot_r[SLOT_W-1:0]) * AW'(stok_pkg::NAME_CHARS) + AW'(pos_r[CHAR_W-1:0]);
    st_wa = AW'(next_slot_r[SLOT_W-1:0]) * AW'(stok_pkg::NAME_CHARS) +
            AW'(pos_r[CHAR_W-1:0]);
    ln_ra = slot_r[SLOT_W-1:0];
    ln_wa = next_slot_r[SLOT_W-1:0];
  end

  always_comb begin
    tok_t t;
    logic [4:0] d;
    logic       go;
    seq_nxt = seq_r;   mode_nxt = mode_r;  ch_nxt = ch_r;  end_nxt = end_r;
    len_nxt = len_r;   num_nxt = num_r;    next_slot_nxt = next_slot_r;
    str_ord_nxt = str_ord_r; paren_nxt = paren_r; brace_nxt = brace_r;
    slot_nxt = slot_r; pos_nxt = pos_r;
    q_nxt[0] = q_r[0]; q_nxt[1] = q_r[1];  qn_nxt = qn_r;  qd_nxt = qd_r;
    qh_nxt = qh_r;
    tok_we = 1'b0; tok_wa = '0; tok_wd = ch_r;
    st_we = 1'b0; ln_we = 1'b0;
    t = '0; d = '0; go = 1'b0;

    // 'go' means: the lookahead character must now be scanned from start.
    case (seq_r)
      stok_pkg::S_IDLE: begin
        if (out_valid && out_ready) begin
          qd_nxt = qd_r + 2'd1;
          if (qd_r + 2'd1 == qn_r) begin
            qn_nxt = '0; qd_nxt = '0;
          end
        end
        if (in_valid && in_ready) begin
          ch_nxt = in_ch; end_nxt = in_at_end;
          seq_nxt = stok_pkg::S_SCAN;
        end
      end
      stok_pkg::S_SCAN: begin
        seq_nxt = stok_pkg::S_EMIT;
        case (mode_r)
          stok_pkg::M_START: go = 1'b1;
          stok_pkg::M_SLASH: begin
            if (!end_r && ch_r == 8'h2A) begin
              mode_nxt = stok_pkg::M_COMMENT;
            end else begin
              q_nxt[0] = '{stok_pkg::K_DELIM, 31'(stok_pkg::D_SLASH), 3'd0};
              qn_nxt = 2'd1; go = 1'b1;
            end
          end
          stok_pkg::M_COMMENT, stok_pkg::M_CSTAR: begin
            if (end_r) begin
              q_nxt[0] = '{stok_pkg::K_END, 31'd0, 3'd0};
              qn_nxt = 2'd1; mode_nxt = stok_pkg::M_HALT;
            end else if (ch_r == 8'h2A) begin
              mode_nxt = stok_pkg::M_CSTAR;
            end else if (ch_r == 8'h2F && mode_r == stok_pkg::M_CSTAR) begin
              mode_nxt = stok_pkg::M_START;
            end else begin
              mode_nxt = stok_pkg::M_COMMENT;
            end
          end
          stok_pkg::M_STRING: begin
            if (end_r) begin
              q_nxt[0] = '{stok_pkg::K_ERROR, 31'd0, stok_pkg::E_STRING};
              qn_nxt = 2'd1; mode_nxt = stok_pkg::M_HALT;
            end else if (ch_r == 8'h22) begin
              q_nxt[0] = '{stok_pkg::K_STRING, 31'(str_ord_r), 3'd0};
              qn_nxt = 2'd1; str_ord_nxt = str_ord_r + 16'd1;
              mode_nxt = stok_pkg::M_START;
            end
          end
          stok_pkg::M_NUMBER: begin
            if (!end_r && stok_pkg::is_digit(ch_r)) begin
              num_nxt = (mul10 > 36'(stok_pkg::NUM_MAX)) ? stok_pkg::NUM_MAX : mul10[30:0];
            end else begin
              q_nxt[0] = '{stok_pkg::K_NUMBER, num_r, 3'd0};
              qn_nxt = 2'd1; go = 1'b1;
            end
          end
          stok_pkg::M_WORD: begin
            if (!end_r && (stok_pkg::is_letter(ch_r) || stok_pkg::is_digit(ch_r))) begin
              if (len_r >= LEN_W'(stok_pkg::NAME_CHARS)) begin
                q_nxt[0] = '{stok_pkg::K_ERROR, 31'd0, stok_pkg::E_LONG};
                qn_nxt = 2'd1; mode_nxt = stok_pkg::M_HALT;
              end else begin
                tok_we = 1'b1; tok_wa = len_r[CHAR_W-1:0];
                len_nxt = len_r + LEN_W'(1);
              end
            end else if (kw_idx != 5'd0) begin
              q_nxt[0] = '{stok_pkg::K_KEYWORD, 31'(kw_idx), 3'd0};
              qn_nxt = 2'd1; go = 1'b1;
            end else begin
              slot_nxt = (SLOT_W+1)'(1); pos_nxt = '0;
              seq_nxt = stok_pkg::S_SEARCH_RD;
            end
          end
          stok_pkg::M_DELIM: begin
            d = end_r ? 5'd0 : stok_pkg::pair_delim(tok_r[0], ch_r);
            if (d != 5'd0) begin
              q_nxt[0] = '{stok_pkg::K_DELIM, 31'(d), 3'd0};
              qn_nxt = 2'd1; mode_nxt = stok_pkg::M_START;
            end else begin
              d = stok_pkg::single_delim(tok_r[0]);
              if (d == 5'd0 || (d == stok_pkg::D_RPAREN && paren_r == 16'd0) ||
                  (d == stok_pkg::D_RBRACE && brace_r == 16'd0)) begin
                q_nxt[0] = '{stok_pkg::K_ERROR, 31'd0,
                             (d == 5'd0) ? stok_pkg::E_DELIM : stok_pkg::E_BRACKET};
                qn_nxt = 2'd1; mode_nxt = stok_pkg::M_HALT;
              end else begin
                if (d == stok_pkg::D_LPAREN && paren_r != stok_pkg::DEPTH_MAX)
                  paren_nxt = paren_r + 16'd1;
                if (d == stok_pkg::D_LBRACE && brace_r != stok_pkg::DEPTH_MAX)
                  brace_nxt = brace_r + 16'd1;
                if (d == stok_pkg::D_RPAREN) paren_nxt = paren_r - 16'd1;
                if (d == stok_pkg::D_RBRACE) brace_nxt = brace_r - 16'd1;
                q_nxt[0] = '{stok_pkg::K_DELIM, 31'(d), 3'd0};
                qn_nxt = 2'd1; go = 1'b1;
              end
            end
          end
          default: mode_nxt = stok_pkg::M_HALT;
        endcase
      end
      // Name table walk: one store read, then one character compare.
      stok_pkg::S_SEARCH_RD: begin
        if (slot_r >= next_slot_r || slot_r >= (SLOT_W+1)'(stok_pkg::NAME_TABLE_SIZE)) begin
          if (next_slot_r >= (SLOT_W+1)'(stok_pkg::NAME_TABLE_SIZE)) begin
            q_nxt[0] = '{stok_pkg::K_ERROR, 31'd0, stok_pkg::E_FULL};
            qn_nxt = 2'd1; mode_nxt = stok_pkg::M_HALT;
            seq_nxt = stok_pkg::S_EMIT;
          end else begin
            pos_nxt = '0; seq_nxt = stok_pkg::S_COPY;
          end
        end else begin
          seq_nxt = stok_pkg::S_SEARCH_CMP;
        end
      end
      stok_pkg::S_SEARCH_CMP: begin
        if (pos_r == '0 && LEN_W'(ln_rd) != len_r) begin
          slot_nxt = slot_r + (SLOT_W+1)'(1); pos_nxt = '0;
          seq_nxt = stok_pkg::S_SEARCH_RD;
        end else if (pos_r < len_r && st_rd != tok_r[pos_r[CHAR_W-1:0]]) begin
          slot_nxt = slot_r + (SLOT_W+1)'(1); pos_nxt = '0;
          seq_nxt = stok_pkg::S_SEARCH_RD;
        end else if (pos_r + LEN_W'(1) >= len_r) begin
          q_nxt[0] = '{stok_pkg::K_IDENT, 31'(slot_r), 3'd0};
          qn_nxt = 2'd1; go = 1'b1;
        end else begin
          pos_nxt = pos_r + LEN_W'(1); seq_nxt = stok_pkg::S_SEARCH_RD;
        end
      end
      stok_pkg::S_COPY: begin
        st_we = 1'b1;
        if (pos_r + LEN_W'(1) >= len_r) begin
          ln_we = 1'b1;
          q_nxt[0] = '{stok_pkg::K_IDENT, 31'(next_slot_r), 3'd0};
          qn_nxt = 2'd1; go = 1'b1;
          next_slot_nxt = next_slot_r + (SLOT_W+1)'(1);
        end else begin
          pos_nxt = pos_r + LEN_W'(1);
        end
      end
      default: begin
        seq_nxt = stok_pkg::S_IDLE;
      end
    endcase

    // Scan the lookahead character from the between-tokens mode.
    if (go) begin
      seq_nxt = stok_pkg::S_EMIT;
      t = '{stok_pkg::K_END, 31'd0, 3'd0};
      if (end_r) begin
        q_nxt[qn_nxt[0]] = t;
        qn_nxt = qn_nxt + 2'd1;
        mode_nxt = stok_pkg::M_HALT;
      end else if (ch_r == 8'h20 || ch_r == 8'h09 || ch_r == 8'h0D || ch_r == 8'h0A) begin
        mode_nxt = stok_pkg::M_START;
      end else if (ch_r == 8'h2F) begin
        mode_nxt = stok_pkg::M_SLASH;
      end else if (ch_r == 8'h22) begin
        mode_nxt = stok_pkg::M_STRING;
      end else if (stok_pkg::is_letter(ch_r)) begin
        tok_we = 1'b1; tok_wa = '0; len_nxt = LEN_W'(1);
        mode_nxt = stok_pkg::M_WORD;
      end else if (stok_pkg::is_digit(ch_r)) begin
        num_nxt = 31'(ch_r - 8'h30);
        mode_nxt = stok_pkg::M_NUMBER;
      end else begin
        tok_we = 1'b1; tok_wa = '0; len_nxt = LEN_W'(1);
        mode_nxt = stok_pkg::M_DELIM;
      end
    end

    if (seq_r == stok_pkg::S_EMIT) begin
      seq_nxt = stok_pkg::S_IDLE;
    end
    qh_nxt = (mode_nxt == stok_pkg::M_HALT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= stok_pkg::S_IDLE;
      mode_r <= stok_pkg::M_START;
      len_r <= '0;
      num_r <= '0;
      next_slot_r <= (SLOT_W+1)'(1);
      str_ord_r <= '0;
      paren_r <= '0;
      brace_r <= '0;
      qn_r <= '0;
      qd_r <= '0;
      qh_r <= 1'b0;
      slot_r <= '0;
      pos_r <= '0;
    end else begin
      // A halted block still takes beats but scans nothing.
      seq_r <= (qh_r && seq_nxt == stok_pkg::S_SCAN) ? stok_pkg::S_IDLE : seq_nxt;
      mode_r <= mode_nxt;
      len_r <= len_nxt;
      num_r <= num_nxt;
      next_slot_r <= next_slot_nxt;
      str_ord_r <= str_ord_nxt;
      paren_r <= paren_nxt;
      brace_r <= brace_nxt;
      qn_r <= qn_nxt;
      qd_r <= qd_nxt;
      qh_r <= qh_nxt;
      slot_r <= slot_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    end_r <= end_nxt;
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
    if (tok_we) begin
      tok_r[tok_wa] <= tok_wd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stok_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module stok_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
